### hdl/dpd_pkg.sv
`default_nettype none

package dpd_pkg;

    localparam int LEN_W      = 11;
    localparam int MAX_PACKET = 1024;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PACKET);

    localparam logic [7:0] CH_START  = 8'h24;
    localparam logic [7:0] CH_END    = 8'h23;
    localparam logic [7:0] CH_ESCAPE = 8'h7d;
    localparam logic [7:0] ESC_XOR   = 8'h20;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [1:0] KIND_FAIL    = 2'd2;
    localparam logic [1:0] KIND_RESTART = 2'd3;

    localparam logic [1:0] ACK_NONE  = 2'd0;
    localparam logic [1:0] ACK_PLUS  = 2'd1;
    localparam logic [1:0] ACK_MINUS = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_BODY = 4'b0010,
        PH_DIG1 = 4'b0100,
        PH_DIG2 = 4'b1000
    } t_phase;

    typedef struct packed {
        logic       bad;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.bad = 1'b0;
        h.val = 4'd0;
        if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h57);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h37);
        end else begin
            h.bad = 1'b1;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

### hdl/dpd_if.sv
`default_nettype none

interface dpd_rx_if import dpd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dpd_res_if import dpd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       kind;
    logic [7:0]       payload_byte;
    logic [LEN_W-1:0] packet_length;
    logic             length_overflow;
    logic [1:0]       ack_code;

    modport source (output valid, output kind, output payload_byte, output packet_length,
                    output length_overflow, output ack_code, input ready);
    modport sink   (input valid, input kind, input payload_byte, input packet_length,
                    input length_overflow, input ack_code, output ready);
endinterface

`default_nettype wire

### hdl/debug_packet_deframer_top.sv
// Remote-debug packet deframer, one received byte per beat.
// i_rx (sink): raw serial characters. o_res (source): at most one result
// beat per input byte: an unescaped payload byte, or at packet end an
// accept/fail/restart beat with length, overflow flag and ack request.
// i_cfg_we / i_cfg_wdata: no-ack mode; the user must write it only while
// the block is idle; the block does not enforce this. A result appears
// on o_res in the cycle after its byte is taken. One byte per cycle while
// o_res does not stall; the framing state and the checksum update in the
// cycle the byte is taken, and a single output register holds the result.
// Stall: i_rx.ready stays high while the output register is empty or is
// being drained in the same cycle; while o_res is stalled with a result
// pending, input is held off and the result stays unchanged.
// Reset (synchronous, active low): framing state goes to idle waiting for
// '$', sums and counts clear, no-ack mode clears, no result pending.
`default_nettype none

module debug_packet_deframer_top import dpd_pkg::*; (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire              i_cfg_wdata,
    dpd_rx_if.sink           i_rx,
    dpd_res_if.source        o_res
);

    t_phase           r_phase, n_phase;
    logic             r_esc, n_esc;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_rsum, n_rsum;
    logic             r_bad, n_bad;
    logic [LEN_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic             r_no_ack;

    logic             r_out_valid;
    logic [1:0]       r_kind, n_kind;
    logic [7:0]       r_pbyte, n_pbyte;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_len_ovf, n_len_ovf;
    logic [1:0]       r_ack, n_ack;
    logic             n_emit;

    logic             in_acc;
    t_hex             hex;
    logic             dig_bad;
    logic [7:0]       dig_sum;
    logic             chk_ok;
    logic [7:0]       b;

    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign in_acc     = i_rx.valid && i_rx.ready;

    assign b       = i_rx.rx_byte;
    assign hex     = hex_decode(b);
    assign dig_bad = r_bad || hex.bad;
    assign dig_sum = hex.bad ? r_rsum : r_rsum + {4'd0, hex.val};
    assign chk_ok  = !dig_bad && (dig_sum == r_sum);

    always_comb begin
        n_phase   = r_phase;
        n_esc     = r_esc;
        n_sum     = r_sum;
        n_rsum    = r_rsum;
        n_bad     = r_bad;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_emit    = 1'b0;
        n_kind    = KIND_PAYLOAD;
        n_pbyte   = 8'd0;
        n_len     = '0;
        n_len_ovf = 1'b0;
        n_ack     = ACK_NONE;
        unique case (r_phase)
            PH_IDLE: begin
                if (b == CH_START) begin
                    n_phase = PH_BODY;
                    n_esc   = 1'b0;
                    n_sum   = 8'd0;
                    n_rsum  = 8'd0;
                    n_bad   = 1'b0;
                    n_count = '0;
                    n_ovf   = 1'b0;
                end
            end
            PH_BODY: begin
                if (b == CH_START) begin
                    n_emit    = 1'b1;
                    n_kind    = KIND_RESTART;
                    n_len     = r_count;
                    n_len_ovf = r_ovf;
                    n_esc     = 1'b0;
                    n_sum     = 8'd0;
                    n_rsum    = 8'd0;
                    n_bad     = 1'b0;
                    n_count   = '0;
                    n_ovf     = 1'b0;
                end else if (b == CH_END) begin
                    n_esc   = 1'b0;
                    n_phase = PH_DIG1;
                end else begin
                    n_sum = r_sum + b;
                    if (b == CH_ESCAPE) begin
                        n_esc = 1'b1;
                    end else begin
                        n_esc   = 1'b0;
                        n_emit  = 1'b1;
                        n_pbyte = r_esc ? (b ^ ESC_XOR) : b;
                        if (r_count >= MAX_LEN) begin
                            n_count = MAX_LEN;
                            n_ovf   = 1'b1;
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end
                end
            end
            PH_DIG1: begin
                n_bad   = hex.bad;
                n_rsum  = hex.bad ? 8'd0 : {hex.val, 4'd0};
                n_phase = PH_DIG2;
            end
            PH_DIG2: begin
                n_emit    = 1'b1;
                n_kind    = chk_ok ? KIND_ACCEPT : KIND_FAIL;
                n_len     = r_count;
                n_len_ovf = r_ovf;
                n_ack     = r_no_ack ? ACK_NONE : (chk_ok ? ACK_PLUS : ACK_MINUS);
                n_phase   = PH_IDLE;
                n_esc     = 1'b0;
                n_sum     = 8'd0;
                n_rsum    = 8'd0;
                n_bad     = 1'b0;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_esc       <= 1'b0;
            r_sum       <= 8'd0;
            r_rsum      <= 8'd0;
            r_bad       <= 1'b0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_no_ack    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_no_ack <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_phase     <= n_phase;
                r_esc       <= n_esc;
                r_sum       <= n_sum;
                r_rsum      <= n_rsum;
                r_bad       <= n_bad;
                r_count     <= n_count;
                r_ovf       <= n_ovf;
                r_out_valid <= n_emit;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc && n_emit) begin
            r_kind    <= n_kind;
            r_pbyte   <= n_pbyte;
            r_len     <= n_len;
            r_len_ovf <= n_len_ovf;
            r_ack     <= n_ack;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.kind            = r_kind;
    assign o_res.payload_byte    = r_pbyte;
    assign o_res.packet_length   = r_len;
    assign o_res.length_overflow = r_len_ovf;
    assign o_res.ack_code        = r_ack;

`ifndef ASSERT_OFF
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_LEN)
        else $error("byte count above limit");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_count == MAX_LEN)
        else $error("overflow flag without saturated count");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_kind == KIND_PAYLOAD |-> r_ack == ACK_NONE && r_len == '0
                                                  && !r_len_ovf)
        else $error("payload beat carries end fields");

    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_phase == PH_DIG2 |=> r_out_valid && r_phase == PH_IDLE
                                         && (r_kind == KIND_ACCEPT || r_kind == KIND_FAIL))
        else $error("second checksum digit gave no end beat");
`endif

endmodule

`default_nettype wire

### bench/deframe_checker.sv
`timescale 1ns / 100ps

module deframe_checker import dpd_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_cfg_we,
    input  wire  i_cfg_wdata,
    dpd_rx_if    i_rx,
    dpd_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       payload_byte;
        logic [LEN_W-1:0] packet_length;
        logic             length_overflow;
        logic [1:0]       ack_code;
    } t_frame_res;

    t_frame_res deframed_q[$];

    t_phase     phase;
    logic       no_ack;
    logic       esc_pend;
    logic [7:0] body_sum;
    logic [7:0] rx_sum;
    logic       digit_bad;
    int         byte_cnt;
    logic       cnt_ovf;
    int         fail_cnt;
    int         beat_idx;

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - 8'h30;
        if (c >= "a" && c <= "f") return int'(c) - 8'h61 + 10;
        if (c >= "A" && c <= "F") return int'(c) - 8'h41 + 10;
        return -1;
    endfunction

    task automatic open_frame();
        phase     = PH_BODY;
        esc_pend  = 1'b0;
        body_sum  = 8'd0;
        rx_sum    = 8'd0;
        digit_bad = 1'b0;
        byte_cnt  = 0;
        cnt_ovf   = 1'b0;
    endtask

    task automatic deframe_byte(input logic [7:0] b, output bit has_res, output t_frame_res r);
        int d;
        bit ok;
        r       = '0;
        has_res = 1'b0;
        case (phase)
            PH_IDLE: begin
                if (b == CH_START) open_frame();
            end
            PH_BODY: begin
                if (b == CH_START) begin
                    r.kind            = KIND_RESTART;
                    r.packet_length   = LEN_W'(byte_cnt);
                    r.length_overflow = cnt_ovf;
                    has_res           = 1'b1;
                    open_frame();
                end else if (b == CH_END) begin
                    esc_pend = 1'b0;
                    phase    = PH_DIG1;
                end else begin
                    body_sum = body_sum + b;
                    if (b == CH_ESCAPE) begin
                        esc_pend = 1'b1;
                    end else begin
                        r.kind         = KIND_PAYLOAD;
                        r.payload_byte = esc_pend ? (b ^ ESC_XOR) : b;
                        esc_pend       = 1'b0;
                        if (byte_cnt >= MAX_PACKET) cnt_ovf = 1'b1;
                        else byte_cnt++;
                        has_res = 1'b1;
                    end
                end
            end
            PH_DIG1: begin
                d         = hex_digit(b);
                digit_bad = (d < 0);
                rx_sum    = (d < 0) ? 8'd0 : 8'(d << 4);
                phase     = PH_DIG2;
            end
            default: begin
                d = hex_digit(b);
                if (d < 0) digit_bad = 1'b1;
                else rx_sum = rx_sum + 8'(d);
                ok                = !digit_bad && rx_sum == body_sum;
                r.kind            = ok ? KIND_ACCEPT : KIND_FAIL;
                r.packet_length   = LEN_W'(byte_cnt);
                r.length_overflow = cnt_ovf;
                r.ack_code        = no_ack ? ACK_NONE : (ok ? ACK_PLUS : ACK_MINUS);
                has_res           = 1'b1;
                phase             = PH_IDLE;
                esc_pend          = 1'b0;
                body_sum          = 8'd0;
                rx_sum            = 8'd0;
                digit_bad         = 1'b0;
            end
        endcase
    endtask

    initial begin
        fail_cnt = 0;
        beat_idx = 0;
    end

    always @(posedge i_clk) begin : watch
        t_frame_res want;
        t_frame_res seen;
        bit         has_res;
        if (!i_rst_n) begin
            phase     = PH_IDLE;
            no_ack    = 1'b0;
            esc_pend  = 1'b0;
            body_sum  = 8'd0;
            rx_sum    = 8'd0;
            digit_bad = 1'b0;
            byte_cnt  = 0;
            cnt_ovf   = 1'b0;
            deframed_q.delete();
        end else begin
            // result beat first: it always comes from an earlier input beat
            if (i_res.valid && i_res.ready) begin
                seen.kind            = i_res.kind;
                seen.payload_byte    = i_res.payload_byte;
                seen.packet_length   = i_res.packet_length;
                seen.length_overflow = i_res.length_overflow;
                seen.ack_code        = i_res.ack_code;
                if (deframed_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("beat %0d: unexpected result, kind %0d byte %02h len %0d",
                                 beat_idx, seen.kind, seen.payload_byte, seen.packet_length);
                end else begin
                    want = deframed_q.pop_front();
                    if (seen.kind !== want.kind || seen.payload_byte !== want.payload_byte
                        || seen.packet_length !== want.packet_length
                        || seen.length_overflow !== want.length_overflow
                        || seen.ack_code !== want.ack_code) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $write("beat %0d (expected/actual): kind %0d/%0d byte %02h/%02h",
                                   beat_idx, want.kind, seen.kind,
                                   want.payload_byte, seen.payload_byte);
                            $display(" len %0d/%0d ovf %0d/%0d ack %0d/%0d",
                                     want.packet_length, seen.packet_length,
                                     want.length_overflow, seen.length_overflow,
                                     want.ack_code, seen.ack_code);
                        end
                    end
                end
                beat_idx++;
            end
            if (i_rx.valid && i_rx.ready) begin
                deframe_byte(i_rx.rx_byte, has_res, want);
                if (has_res) deframed_q = {deframed_q, want};
            end
            if (i_cfg_we) no_ack = i_cfg_wdata;
        end
        o_fail_count <= fail_cnt;
        o_pending    <= deframed_q.size();
    end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import dpd_pkg::*;

    localparam int CS_GOOD      = 0;
    localparam int CS_WRONG     = 1;
    localparam int CS_BAD_DIGIT = 2;

    localparam int RANDOM_BYTES = 400;
    localparam int N_PHASES     = 4;

    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   fail_count;
    int   pending;

    dpd_rx_if  rx_if();
    dpd_res_if res_if();

    logic [7:0] body_q[$];
    logic [7:0] frame_q[$];
    bit         quiet;
    int         stall_left;
    int         bytes_sent;
    int         seqs_sent;

    debug_packet_deframer_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_rx        (rx_if),
        .o_res       (res_if)
    );

    deframe_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_rx         (rx_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CH_START || b == CH_END || b == CH_ESCAPE);
        return b;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 10) return 8'h30 + 8'(v);
        return (upper ? 8'h37 : 8'h57) + 8'(v);
    endfunction

    function automatic logic [7:0] junk_digit();
        case ($urandom_range(0, 2))
            0:       return 8'h67 + 8'($urandom_range(0, 19));
            1:       return 8'h47 + 8'($urandom_range(0, 19));
            default: return 8'($urandom_range(0, 8'h2f));
        endcase
    endfunction

    // result side: random stalls
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 99) < 20) stall_left <= pick_gap();
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge clk); while (!rx_if.ready);
        bytes_sent++;
        gap = (!quiet && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_frame();
        while (frame_q.size() > 0) send_byte(frame_q.pop_front());
        seqs_sent++;
    endtask

    // one payload byte per unit, escaped ones included
    task automatic fill_body(input int len);
        repeat (len) begin
            if ($urandom_range(0, 9) == 0) begin
                body_q = {body_q, CH_ESCAPE};
                if ($urandom_range(0, 7) == 0) body_q = {body_q, CH_ESCAPE};
                case ($urandom_range(0, 3))
                    0:       body_q = {body_q, CH_START ^ ESC_XOR};
                    1:       body_q = {body_q, CH_END ^ ESC_XOR};
                    2:       body_q = {body_q, CH_ESCAPE ^ ESC_XOR};
                    default: body_q = {body_q, plain_byte()};
                endcase
            end else begin
                body_q = {body_q, plain_byte()};
            end
        end
    endtask

    task automatic queue_frame(input int cs_mode);
        logic [7:0] sum;
        logic [7:0] cs;
        bit         upper;
        int         bad_pos;
        sum = 8'd0;
        frame_q = {frame_q, CH_START};
        foreach (body_q[k]) begin
            sum = sum + body_q[k];
            frame_q = {frame_q, body_q[k]};
        end
        frame_q = {frame_q, CH_END};
        upper   = $urandom_range(0, 1);
        bad_pos = $urandom_range(0, 2);
        cs      = (cs_mode == CS_WRONG) ? sum + 8'($urandom_range(1, 255)) : sum;
        frame_q = {frame_q, (cs_mode == CS_BAD_DIGIT && bad_pos != 1) ? junk_digit()
                                                                      : hex_char(cs[7:4], upper)};
        frame_q = {frame_q, (cs_mode == CS_BAD_DIGIT && bad_pos != 0) ? junk_digit()
                                                                      : hex_char(cs[3:0], upper)};
        body_q.delete();
    endtask

    function automatic int pick_cs_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return CS_GOOD;
        if (r < 88) return CS_WRONG;
        return CS_BAD_DIGIT;
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(0, 8);
        if (r < 90) return $urandom_range(9, 40);
        return $urandom_range(41, 200);
    endfunction

    task automatic drain();
        rx_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_no_ack(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int target;
        int sel;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        quiet         = 1'b0;
        bytes_sent    = 0;
        seqs_sent     = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_no_ack(1'b0);

        // directed
        frame_q = {CH_PLUS, CH_MINUS, 8'hff};
        send_frame();
        body_q = {8'h00, 8'hff, CH_ESCAPE, CH_ESCAPE, CH_ESCAPE};
        queue_frame(CS_GOOD);
        send_frame();
        frame_q = {CH_START, 8'h41};
        body_q  = {8'h42};
        queue_frame(CS_BAD_DIGIT);
        send_frame();
        queue_frame(CS_WRONG);
        send_frame();
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_no_ack(ph % 2 == 0);
            if (ph == 2) begin
                // at the length limit or a few bytes past it
                fill_body(MAX_PACKET + $urandom_range(0, 8));
                queue_frame(pick_cs_mode());
                send_frame();
            end
            target = bytes_sent + RANDOM_BYTES / N_PHASES;
            while (bytes_sent < target) begin
                if ($urandom_range(0, 9) == 0) quiet = !quiet;
                sel = $urandom_range(0, 99);
                if (sel < 80) begin
                    fill_body(pick_len());
                    queue_frame(pick_cs_mode());
                end else if (sel < 90) begin
                    repeat ($urandom_range(1, 6))
                        case ($urandom_range(0, 3))
                            0:       frame_q = {frame_q, CH_PLUS};
                            1:       frame_q = {frame_q, CH_MINUS};
                            default: frame_q = {frame_q, 8'($urandom_range(0, 255))};
                        endcase
                end else begin
                    case ($urandom_range(0, 2))
                        0: begin
                            // abandoned body, then a fresh start
                            fill_body($urandom_range(0, 12));
                            frame_q = {frame_q, CH_START};
                            foreach (body_q[k]) frame_q = {frame_q, body_q[k]};
                            body_q.delete();
                            fill_body($urandom_range(0, 12));
                        end
                        1: begin
                            fill_body($urandom_range(0, 12));
                            body_q = {body_q, CH_ESCAPE};
                        end
                        default: ;
                    endcase
                    queue_frame(pick_cs_mode());
                end
                send_frame();
            end
            // '#00' returns the framer to idle from any state
            frame_q = {CH_END, 8'h30, 8'h30};
            send_frame();
            drain();
        end

        $display("Sent %0d bytes in %0d sequences with ack requests on and off,",
                 bytes_sent, seqs_sent);
        $display("including one packet of at least %0d payload bytes.", MAX_PACKET);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
